[rtl/assert_macros.svh]
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define PBT_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// condition must never be true out of reset
`define PBT_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define PBT_ASSERT(label, clk, rst_n, prop)
`define PBT_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

[rtl/pbt_pkg.sv]
// shared constants and types for the prefix to border table block
package pbt_pkg;

    localparam int MAX_LEN = 1024;
    localparam int IDX_W   = $clog2(MAX_LEN);
    localparam int VAL_W   = IDX_W + 1;
    // index plus prefix value, one bit of headroom
    localparam int REACH_W = VAL_W + 1;

    // transaction kinds
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // border memory write request from the walk sequencer
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] addr;
        logic [VAL_W-1:0] data;
    } t_wr_req;

    // walk sequencer status toward the top level
    typedef struct packed {
        logic busy;
        logic done;
    } t_walk_stat;

endpackage

[rtl/prefix_to_border_table.sv]
// top level of the prefix table to border table converter
`include "assert_macros.svh"

// Loads give no result. A read's result appears on the output ports, marked by
// o_strobe, in the cycle after the read is accepted; reads may be issued every
// cycle while busy is low. The load marked last starts the border walk, and busy
// stays high until the walk has written every border entry up to the last index:
// the walk fetches prefix entries from the prefix memory one at a time and writes
// the border entries that each one covers, or zero where none does.
// Reads made before a walk has finished, or after a later non-final load, return
// zero with o_done_res low. Results cannot be stalled by the receiver.
module prefix_to_border_table (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      i_kind,
    input  logic [pbt_pkg::IDX_W-1:0] i_index,
    input  logic [pbt_pkg::VAL_W-1:0] i_prefix_value,
    input  logic                      i_last,
    output logic                      o_strobe,
    output logic [pbt_pkg::VAL_W-1:0] o_border_value,
    output logic                      o_done_res
);
    import pbt_pkg::*;

    logic             w_accept;
    logic             w_load;
    logic             w_read;
    logic [IDX_W-1:0] w_prefix_addr;
    logic [VAL_W-1:0] w_prefix_data;
    logic [VAL_W-1:0] w_border_data;
    t_wr_req          w_wr;
    t_walk_stat       w_stat;

    logic             r_computed;
    logic [IDX_W-1:0] r_last_idx;
    logic             r_strobe;
    logic             r_hit;
    logic             r_done;

    // transaction decode
    assign w_accept = start && !busy;
    assign w_load   = w_accept && (i_kind == KIND_LOAD);
    assign w_read   = w_accept && (i_kind == KIND_READ);

    // prefix table storage
    pbt_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MAX_LEN)
    ) u_prefix_ram (
        .i_clk   (i_clk),
        .i_we    (w_load),
        .i_waddr (i_index),
        .i_wdata (i_prefix_value),
        .i_raddr (w_prefix_addr),
        .o_rdata (w_prefix_data)
    );

    // border table storage, read by transactions while idle
    pbt_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MAX_LEN)
    ) u_border_ram (
        .i_clk   (i_clk),
        .i_we    (w_wr.we),
        .i_waddr (w_wr.addr),
        .i_wdata (w_wr.data),
        .i_raddr (i_index),
        .o_rdata (w_border_data)
    );

    // border walk
    pbt_walk u_walk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_go          (w_load && i_last),
        .i_last_idx    (i_index),
        .i_prefix      (w_prefix_data),
        .o_prefix_addr (w_prefix_addr),
        .o_wr          (w_wr),
        .o_stat        (w_stat)
    );

    assign busy = w_stat.busy;

    // computed flag and table length
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_computed <= 1'b0;
            r_last_idx <= '0;
        end else begin
            if (w_stat.done) begin
                r_computed <= 1'b1;
            end else if (w_load) begin
                r_computed <= 1'b0;
            end
            if (w_load && i_last) begin
                r_last_idx <= i_index;
            end
        end
    end

    // read result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= w_read;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hit  <= r_computed && (i_index <= r_last_idx);
        r_done <= r_computed;
    end

    assign o_strobe       = r_strobe;
    assign o_border_value = r_hit ? w_border_data : '0;
    assign o_done_res     = r_done;

    // checks
    `PBT_ASSERT(a_strobe_from_read, i_clk, i_rst_n, o_strobe |-> $past(w_read))
    `PBT_ASSERT_NEVER(a_strobe_while_busy, i_clk, i_rst_n, o_strobe && busy)
    `PBT_ASSERT(a_walk_not_computed, i_clk, i_rst_n, busy |-> !r_computed)
    `PBT_ASSERT(a_walk_ends_computed, i_clk, i_rst_n, $fell(busy) |-> r_computed)

endmodule

[rtl/pbt_ram.sv]
// simple dual port ram, one write port and one registered read port
module pbt_ram #(
    parameter int WIDTH  = 11,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/pbt_walk.sv]
// sequencer that walks the prefix table and writes the border table
module pbt_walk (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_go,
    input  logic [pbt_pkg::IDX_W-1:0] i_last_idx,
    input  logic [pbt_pkg::VAL_W-1:0] i_prefix,
    output logic [pbt_pkg::IDX_W-1:0] o_prefix_addr,
    output pbt_pkg::t_wr_req          o_wr,
    output pbt_pkg::t_walk_stat       o_stat
);
    import pbt_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_ZERO  = 5'b00010,
        S_FETCH = 5'b00100,
        S_CHECK = 5'b01000,
        S_FILL  = 5'b10000
    } t_state;

    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_i, n_i;
    logic [IDX_W-1:0]   r_j, n_j;
    logic [IDX_W-1:0]   r_last, n_last;
    logic [REACH_W-1:0] r_reach, n_reach;

    logic [REACH_W-1:0] w_reach;
    logic               w_covers;
    logic               w_j_last;
    t_wr_req            w_wr;
    logic               w_done;

    // reach of the current candidate: fresh from memory or held
    assign w_reach  = (r_state == S_CHECK) ? (REACH_W'(r_i) + REACH_W'(i_prefix)) : r_reach;
    assign w_covers = w_reach > REACH_W'(r_j);
    assign w_j_last = (r_j == r_last);

    // next state and border write
    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_j     = r_j;
        n_last  = r_last;
        n_reach = r_reach;
        w_wr    = '0;
        w_done  = 1'b0;
        unique case (r_state) inside
            S_IDLE: begin
                if (i_go) begin
                    n_last  = i_last_idx;
                    n_state = S_ZERO;
                end
            end
            S_ZERO: begin
                w_wr.we   = 1'b1;
                w_wr.addr = '0;
                w_wr.data = '0;
                if (r_last == '0) begin
                    w_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_i     = IDX_W'(1);
                    n_j     = IDX_W'(1);
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                n_state = S_CHECK;
            end
            S_CHECK, S_FILL: begin
                n_reach = w_reach;
                if (w_covers) begin
                    // position lies inside the current candidate's match
                    w_wr.we   = 1'b1;
                    w_wr.addr = r_j;
                    w_wr.data = VAL_W'(r_j - r_i) + VAL_W'(1);
                    if (w_j_last) begin
                        w_done  = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_j     = r_j + IDX_W'(1);
                        n_state = S_FILL;
                    end
                end else if (r_i == r_j) begin
                    // no candidate covers this position
                    w_wr.we   = 1'b1;
                    w_wr.addr = r_j;
                    w_wr.data = '0;
                    if (w_j_last) begin
                        w_done  = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_i     = r_i + IDX_W'(1);
                        n_j     = r_j + IDX_W'(1);
                        n_state = S_FETCH;
                    end
                end else begin
                    // candidate exhausted, try the next one
                    n_i     = r_i + IDX_W'(1);
                    n_state = S_FETCH;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // pointers and cached reach
    always_ff @(posedge i_clk) begin
        r_i     <= n_i;
        r_j     <= n_j;
        r_last  <= n_last;
        r_reach <= n_reach;
    end

    assign o_prefix_addr = r_i;
    assign o_wr          = w_wr;
    assign o_stat.busy   = (r_state != S_IDLE);
    assign o_stat.done   = w_done;

endmodule

[tb/sv/prefix_to_border_table_tb.sv]
// self-checking testbench for the prefix table to border table converter
`timescale 1ns / 1ps

module prefix_to_border_table_tb;
    import pbt_pkg::*;

    localparam int     CLK_PERIOD = 8;
    localparam int     IDX_MAX    = MAX_LEN - 1;
    localparam int     VAL_TOP    = 1024;
    localparam int     ITEM_GOAL  = 2030;
    localparam int     CALM_FROM  = 1800;
    localparam int     FULL_AT    = 600;
    localparam longint TIMEOUT_NS = 200_000_000;

    // one expected read transaction outcome
    typedef struct {
        logic [VAL_W-1:0] border;
        logic             done;
    } t_border_result;

    // prediction of the border table and check of read results
    class t_border_checker;
        logic [VAL_W-1:0] prefix_mem [MAX_LEN];
        logic [VAL_W-1:0] border_mem [MAX_LEN];
        int unsigned      tbl_len;
        int unsigned      next_free;
        bit               computed;
        t_border_result   pending_borders [$];
        int unsigned      n_errors;

        function new();
            foreach (prefix_mem[k]) begin
                prefix_mem[k] = '0;
                border_mem[k] = '0;
            end
            tbl_len   = 0;
            next_free = 1;
            computed  = 1'b0;
            n_errors  = 0;
        endfunction

        function void flag_error(string msg);
            n_errors++;
            if (n_errors <= 10)
                $display("%s", msg);
        endfunction

        // border walk over the loaded prefix table
        function void build_borders();
            int unsigned p;
            int unsigned reach;
            int unsigned first;
            foreach (border_mem[k])
                border_mem[k] = '0;
            next_free = 1;
            for (int unsigned i = 1; i < tbl_len; i++) begin
                p = 32'(prefix_mem[i]);
                if (p == 0)
                    continue;
                reach = i + p - 1;
                if (reach > tbl_len - 1)
                    reach = tbl_len - 1;
                first = (next_free > i) ? next_free : i;
                if (reach < first)
                    continue;
                for (int unsigned j = first; j <= reach; j++)
                    border_mem[j] = VAL_W'(j - i + 1);
                next_free = (reach + 1) & ((1 << VAL_W) - 1);
            end
            computed = 1'b1;
        endfunction

        // accepted transaction: update state, queue a result for reads
        function void note_transaction(logic kind, logic [IDX_W-1:0] idx,
                                       logic [VAL_W-1:0] val, logic last);
            t_border_result exp_res;
            if (kind == KIND_LOAD) begin
                prefix_mem[idx] = val;
                if (last) begin
                    tbl_len = int'(idx) + 1;
                    build_borders();
                end else begin
                    computed = 1'b0;
                end
            end else begin
                exp_res.border = (computed && idx < tbl_len) ? border_mem[idx] : '0;
                exp_res.done   = computed;
                pending_borders.insert(pending_borders.size(), exp_res);
            end
        endfunction

        function void check_result(logic [VAL_W-1:0] border, logic done);
            t_border_result exp_res;
            if (pending_borders.size() == 0) begin
                flag_error($sformatf("unexpected result: value %0d done %0b", border, done));
            end else begin
                exp_res = pending_borders.pop_front();
                if (border !== exp_res.border)
                    flag_error($sformatf("border value mismatch: expected %0d, got %0d",
                                         exp_res.border, border));
                if (done !== exp_res.done)
                    flag_error($sformatf("done flag mismatch: expected %0b, got %0b",
                                         exp_res.done, done));
            end
        endfunction

        function void check_drained();
            t_border_result exp_res;
            while (pending_borders.size() != 0) begin
                exp_res = pending_borders.pop_front();
                flag_error($sformatf("missing result: expected value %0d done %0b",
                                     exp_res.border, exp_res.done));
            end
        endfunction
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    logic             i_kind;
    logic [IDX_W-1:0] i_index;
    logic [VAL_W-1:0] i_prefix_value;
    logic             i_last;
    logic             o_strobe;
    logic [VAL_W-1:0] o_border_value;
    logic             o_done_res;

    t_border_checker board;
    int unsigned     table_vals [MAX_LEN];
    bit              prefix_written [MAX_LEN];
    int              n_sent;
    bit              idle_on;

    prefix_to_border_table dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_kind         (i_kind),
        .i_index        (i_index),
        .i_prefix_value (i_prefix_value),
        .i_last         (i_last),
        .o_strobe       (o_strobe),
        .o_border_value (o_border_value),
        .o_done_res     (o_done_res)
    );

    // clock
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // monitor: check results, then record accepted transactions
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe)
                board.check_result(o_border_value, o_done_res);
            if (start && !busy)
                board.note_transaction(i_kind, i_index, i_prefix_value, i_last);
        end
    end

    // idle the sender, with junk on the payload
    task automatic pause_cycles(input int n);
        start          <= 1'b0;
        i_kind         <= 1'($urandom_range(0, 1));
        i_index        <= IDX_W'($urandom_range(0, IDX_MAX));
        i_prefix_value <= VAL_W'($urandom_range(0, (1 << VAL_W) - 1));
        i_last         <= 1'($urandom_range(0, 1));
        repeat (n) @(negedge i_clk);
    endtask

    // drive one transaction and wait until it is accepted
    task automatic send_item(input logic kind, input logic [IDX_W-1:0] idx,
                             input logic [VAL_W-1:0] val, input logic last);
        if (idle_on && $urandom_range(0, 3) == 0)
            pause_cycles($urandom_range(1, 3));
        start          <= 1'b1;
        i_kind         <= kind;
        i_index        <= idx;
        i_prefix_value <= val;
        i_last         <= last;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        @(negedge i_clk);
        n_sent++;
        if (kind == KIND_LOAD)
            prefix_written[idx] = 1'b1;
    endtask

    task automatic load_entry(input int idx, input int val, input bit last);
        send_item(KIND_LOAD, IDX_W'(idx), VAL_W'(val), last);
    endtask

    task automatic read_entry(input int idx);
        send_item(KIND_READ, IDX_W'(idx), VAL_W'($urandom_range(0, (1 << VAL_W) - 1)),
                  1'($urandom_range(0, 1)));
    endtask

    // hold off until every queued read result has come back
    task automatic wait_drained();
        start <= 1'b0;
        do
            @(negedge i_clk);
        while (board.pending_borders.size() != 0);
    endtask

    // highest index a final load may use without an unwritten entry in the walk
    function automatic int max_last_index();
        for (int k = 1; k < MAX_LEN; k++)
            if (!prefix_written[k])
                return k;
        return IDX_MAX;
    endfunction

    function automatic int noise_value(input int len);
        case ($urandom_range(0, 5))
            0: return 0;
            1: return VAL_TOP;
            2, 3: return $urandom_range(0, len);
            default: return $urandom_range(0, VAL_TOP);
        endcase
    endfunction

    // true prefix table of a random string over a small alphabet
    function automatic void make_z_table(input int len);
        int           alpha;
        int           n;
        byte unsigned text [MAX_LEN];
        alpha = $urandom_range(1, 3);
        for (int k = 0; k < len; k++)
            text[k] = 8'($urandom_range(0, alpha - 1));
        table_vals[0] = len;
        for (int i = 1; i < len; i++) begin
            n = 0;
            while (i + n < len && text[n] == text[i + n])
                n++;
            table_vals[i] = n;
        end
    endfunction

    task automatic read_some(input int len);
        repeat ($urandom_range(2, 8)) begin
            if ($urandom_range(0, 4) != 0)
                read_entry($urandom_range(0, len - 1));
            else
                read_entry($urandom_range(0, IDX_MAX));
        end
    endtask

    // full table load with occasional reads mixed in, then reads
    task automatic run_table(input int len, input bit well_formed);
        if (well_formed) begin
            make_z_table(len);
        end else begin
            for (int k = 0; k < len; k++)
                table_vals[k] = noise_value(len);
        end
        for (int k = 0; k < len; k++) begin
            if (k > 0 && $urandom_range(0, 19) == 0)
                read_entry($urandom_range(0, IDX_MAX));
            load_entry(k, table_vals[k], k == len - 1);
        end
        read_some(len);
    endtask

    // table reusing stored entries: one to six rewrites, then the final load and reads
    task automatic touch_table(input int len);
        repeat ($urandom_range(1, 6))
            load_entry($urandom_range(0, len - 2), noise_value(len), 1'b0);
        load_entry(len - 1, noise_value(len), 1'b1);
        read_some(len);
    endtask

    // loose transactions in any order
    task automatic scatter_items();
        int r;
        repeat ($urandom_range(3, 10)) begin
            r = $urandom_range(0, 9);
            if (r < 5)
                read_entry($urandom_range(0, IDX_MAX));
            else if (r < 8)
                load_entry($urandom_range(0, IDX_MAX), noise_value(VAL_TOP), 1'b0);
            else
                load_entry($urandom_range(0, max_last_index()), noise_value(VAL_TOP), 1'b1);
        end
    endtask

    // stimulus
    initial begin
        int  aab_z [6];
        int  r;
        bit  full_done;
        aab_z          = '{6, 1, 0, 3, 1, 0};
        board          = new();
        full_done      = 1'b0;
        n_sent         = 0;
        idle_on        = 1'b1;
        foreach (prefix_written[k])
            prefix_written[k] = 1'b0;
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_kind         = KIND_LOAD;
        i_index        = '0;
        i_prefix_value = '0;
        i_last         = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reads before any walk
        read_entry(0);
        read_entry(IDX_MAX);
        // single-entry table with value VAL_TOP, reads inside and beyond it
        load_entry(0, VAL_TOP, 1'b1);
        read_entry(0);
        read_entry(1);
        read_entry(IDX_MAX);
        // prefix table of "aabaab"
        for (int k = 0; k < 6; k++)
            load_entry(k, aab_z[k], k == 5);
        read_entry(3);
        read_entry(4);
        read_entry(5);
        // non-final load clears done, then clamped reach
        load_entry(1, VAL_TOP, 1'b0);
        read_entry(1);
        load_entry(2, 0, 1'b1);
        read_entry(2);
        read_entry(1);

        // random part
        while (n_sent < ITEM_GOAL) begin
            if (!full_done && n_sent > FULL_AT) begin
                wait_drained();
                run_table(MAX_LEN, 1'b1);
                full_done = 1'b1;
            end else begin
                idle_on = (n_sent < CALM_FROM) && ($urandom_range(0, 9) < 7);
                r = $urandom_range(0, 99);
                if (r < 55)
                    run_table($urandom_range(2, 24), 1'b1);
                else if (r < 70)
                    run_table($urandom_range(2, 24), 1'b0);
                else if (r < 75)
                    run_table(1, 1'b0);
                else if (r < 87)
                    scatter_items();
                else if (full_done)
                    touch_table($urandom_range(2, MAX_LEN));
                else
                    run_table($urandom_range(25, 64), 1'b1);
            end
        end

        // drain and report
        wait_drained();
        repeat (8) @(negedge i_clk);
        board.check_drained();
        if (board.n_errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("Some tests failed");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/pbt_pkg.sv
rtl/pbt_ram.sv
rtl/pbt_walk.sv
rtl/prefix_to_border_table.sv
tb/sv/prefix_to_border_table_tb.sv
